// File: hw/rtl/rspm_pkg.sv
// Package for the rowing stroke power meter: widths, constants, shared types.
// No dependencies.
`timescale 1ns / 1ps
package rspm_pkg;
    localparam int unsigned FORCE_FRAC_BITS = 4;
    localparam int unsigned DW = 72;

    localparam logic CFG_PULL    = 1'b0;
    localparam logic CFG_RELEASE = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RATE  = 7'b0000010,
        ST_WATT  = 7'b0000100,
        ST_SPEED = 7'b0001000,
        ST_PACE  = 7'b0010000,
        ST_DIST  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        OP_DIV  = 2'd0,
        OP_CUBE = 2'd1
    } op_t;

    typedef struct packed {
        logic   start;
        op_t    op;
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        logic [17:0]   hi;
    } unit_cmd_t;
endpackage

// File: hw/rtl/rspm_unit.sv
// Shared iterative unit: restoring divide (one quotient bit per cycle) and
// floor cube-root bisection (square, cube, compare per mid). Uses rspm_pkg.
`timescale 1ns / 1ps
module rspm_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  rspm_pkg::unit_cmd_t        cmd,
    output logic                       done,
    output logic [rspm_pkg::DW-1:0]    result
);
    localparam int unsigned W = rspm_pkg::DW;

    logic        busy_reg, busy_next;
    rspm_pkg::op_t op_reg, op_next;
    logic [W-1:0] num_reg, num_next;
    logic [W-1:0] den_reg, den_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [17:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [53:0]  prod_reg, prod_next;
    logic [1:0]   ph_reg, ph_next;
    logic         done_reg, done_next;
    logic [W-1:0] sh;
    logic [17:0]  mid;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign sh  = {rem_reg[W-2:0], num_reg[W-1]};

    always_comb
    begin
        busy_next = busy_reg; op_next = op_reg; num_next = num_reg;
        den_next = den_reg; rem_next = rem_reg; quo_next = quo_reg;
        cnt_next = cnt_reg; lo_next = lo_reg; hi_next = hi_reg;
        prod_next = prod_reg; ph_next = ph_reg; done_next = 1'b0;
        if (!busy_reg)
        begin
            if (cmd.start)
            begin
                busy_next = 1'b1; op_next = cmd.op; num_next = cmd.num;
                den_next = cmd.den; rem_next = '0; quo_next = '0;
                cnt_next = 7'(W); lo_next = '0; hi_next = cmd.hi; ph_next = '0;
            end
        end
        else
        begin
            case (op_reg)
                rspm_pkg::OP_DIV:
                begin
                    if (sh >= den_reg)
                    begin
                        rem_next = sh - den_reg;
                        quo_next = {quo_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = sh;
                        quo_next = {quo_reg[W-2:0], 1'b0};
                    end
                    num_next = {num_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                rspm_pkg::OP_CUBE:
                begin
                    if (hi_reg - lo_reg <= 18'd1)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        quo_next = W'(lo_reg);
                    end
                    else
                    begin
                        case (ph_reg)
                            2'd0:
                            begin
                                prod_next = 54'(mid) * 54'(mid);
                                ph_next = 2'd1;
                            end
                            2'd1:
                            begin
                                prod_next = 54'(prod_reg[35:0]) * 54'(mid);
                                ph_next = 2'd2;
                            end
                            default:
                            begin
                                if (W'(prod_reg) * W'(den_reg[15:0]) <= num_reg)
                                    lo_next = mid;
                                else
                                    hi_next = mid;
                                ph_next = 2'd0;
                            end
                        endcase
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; num_reg <= num_next; den_reg <= den_next;
        rem_reg <= rem_next; quo_reg <= quo_next; cnt_reg <= cnt_next;
        lo_reg <= lo_next; hi_reg <= hi_next; prod_reg <= prod_next;
        ph_reg <= ph_next;
    end

    assign done   = done_reg;
    assign result = quo_reg;
endmodule

// File: hw/rtl/rowing_stroke_power_meter.sv
// Top level of the rowing stroke power meter. Uses rspm_pkg and rspm_unit.
// One force sample in, one status transaction out.
//
// A counted stroke runs rate, power, speed and pace through the shared divide /
// cube-root unit in sequence, with two 72-step restoring divides and 17- and
// 13-step bisections; a stroke with zero power skips the cube roots. Distance
// and energy use constant reciprocal multiplies in the last two states.
`timescale 1ns / 1ps
module rowing_stroke_power_meter
#(
    parameter int unsigned FORCE_FRAC_BITS = rspm_pkg::FORCE_FRAC_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [14:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,    // force_sample[15:0], timestamp_ms[47:16]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata     // pulling[0], stroke_done[1], peak_force[16:2],
                                     // strokes_per_minute[32:17], power_watts[48:33],
                                     // pace_tenths[64:49], distance_cm[96:65],
                                     // energy_millikcal[128:97], stroke_total[160:129],
                                     // zero fill[167:161]
);
    localparam int unsigned W = rspm_pkg::DW;

    rspm_pkg::state_t state_reg;
    rspm_pkg::state_t prev_state_reg;
    logic [14:0] pull_reg, rel_reg;
    logic        drive_reg, seen_reg, done_reg;
    logic [14:0] peak_reg;
    logic [31:0] last_reg, dt_reg, dist_reg, energy_reg, count_reg;
    logic [15:0] rate_reg, power_reg, pace_reg;
    logic [16:0] speed_reg;
    logic [48:0] dprod_reg;
    logic [26:0] ex_reg;
    logic        out_valid_reg;

    rspm_pkg::unit_cmd_t cmd;
    logic        cmd_go;
    logic        u_done;
    logic [W-1:0] u_res;

    logic signed [15:0] force_s;
    logic [31:0] now, dt;
    logic [15:0] sat_res;
    logic [35:0] dx;
    logic [20:0] dy;
    logic [42:0] dy_m;
    logic [33:0] dq;
    logic [54:0] e_m;
    logic [32:0] esum, dsum;
    logic [31:0] e_inc;

    assign force_s = signed'(s_tdata[15:0]);
    assign now     = s_tdata[47:16];
    assign dt      = now - last_reg;
    assign sat_res = (u_res > W'(16'hFFFF)) ? 16'hFFFF : u_res[15:0];

    // distance step: drop 13 bits, then divide by 5 as hi * 52428 + (4 * hi + lo) / 5
    assign dx    = dprod_reg[48:13];
    assign dy    = {1'b0, dx[35:18], 2'b00} + {3'b000, dx[17:0]};
    assign dy_m  = 43'(dy) * 43'd3355444;
    assign dq    = 34'(dx[35:18]) * 34'd52428 + {15'd0, dy_m[42:24]};
    // energy step: divide by 523 with a reciprocal
    assign e_m   = 55'(ex_reg) * 55'd262789586;
    assign e_inc = {14'd0, e_m[54:37]};
    assign esum  = {1'b0, energy_reg} + {1'b0, e_inc};
    assign dsum  = {1'b0, dist_reg} + {1'b0, dq[31:0]};
    assign s_tready = (state_reg == rspm_pkg::ST_IDLE) && !out_valid_reg;

    rspm_unit u_unit (.clk(clk), .rst_n(rst_n), .cmd(cmd), .done(u_done), .result(u_res));

    always_comb
    begin
        cmd_go = (state_reg != prev_state_reg)
                 && (state_reg != rspm_pkg::ST_IDLE)
                 && (state_reg != rspm_pkg::ST_DIST)
                 && (state_reg != rspm_pkg::ST_OUT);
    end

    always_comb
    begin
        cmd = '0;
        cmd.hi = 18'd1;
        case (state_reg)
            rspm_pkg::ST_RATE:
            begin
                cmd.op = rspm_pkg::OP_DIV; cmd.num = W'(60000); cmd.den = W'(dt_reg);
            end
            rspm_pkg::ST_WATT:
            begin
                cmd.op = rspm_pkg::OP_DIV; cmd.num = W'(peak_reg) * W'(5886);
                cmd.den = W'(dt_reg) << FORCE_FRAC_BITS;
            end
            rspm_pkg::ST_SPEED:
            begin
                cmd.op = rspm_pkg::OP_CUBE; cmd.num = (W'(power_reg) * W'(10)) << 36;
                cmd.den = W'(28); cmd.hi = 18'h20000;
            end
            rspm_pkg::ST_PACE:
            begin
                cmd.op = rspm_pkg::OP_CUBE; cmd.num = W'(64'd350000000000);
                cmd.den = W'(power_reg); cmd.hi = 18'd8192;
            end
            default: cmd.op = rspm_pkg::OP_DIV;
        endcase
        cmd.start = cmd_go;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rspm_pkg::ST_IDLE; pull_reg <= 15'd64; rel_reg <= 15'd32;
            drive_reg <= 1'b0; seen_reg <= 1'b0; done_reg <= 1'b0; peak_reg <= '0;
            last_reg <= '0; dist_reg <= '0; energy_reg <= '0; count_reg <= '0;
            rate_reg <= '0; power_reg <= '0; pace_reg <= '0; out_valid_reg <= 1'b0;
            dt_reg <= '0; speed_reg <= '0; dprod_reg <= '0; ex_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == rspm_pkg::CFG_RELEASE)
                    rel_reg <= cfg_data;
                else
                    pull_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                rspm_pkg::ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        done_reg <= 1'b0;
                        if (force_s > signed'({1'b0, pull_reg}))
                        begin
                            drive_reg <= 1'b1;
                            if (!drive_reg)
                                peak_reg <= force_s[14:0];
                            else if (force_s[14:0] > peak_reg)
                                peak_reg <= force_s[14:0];
                            out_valid_reg <= 1'b1;
                        end
                        else if (force_s < signed'({1'b0, rel_reg}) && drive_reg)
                        begin
                            drive_reg <= 1'b0;
                            last_reg <= now;
                            seen_reg <= 1'b1;
                            if (seen_reg && dt >= 32'd2)
                            begin
                                dt_reg <= dt;
                                state_reg <= rspm_pkg::ST_RATE;
                            end
                            else
                                out_valid_reg <= 1'b1;
                        end
                        else
                            out_valid_reg <= 1'b1;
                    end
                end
                rspm_pkg::ST_RATE:
                begin
                    if (u_done)
                    begin
                        rate_reg <= sat_res;
                        state_reg <= rspm_pkg::ST_WATT;
                    end
                end
                rspm_pkg::ST_WATT:
                begin
                    if (u_done)
                    begin
                        power_reg <= sat_res;
                        if (sat_res == 16'd0)
                        begin
                            pace_reg <= '0;
                            speed_reg <= '0;
                            state_reg <= rspm_pkg::ST_DIST;
                        end
                        else
                            state_reg <= rspm_pkg::ST_SPEED;
                    end
                end
                rspm_pkg::ST_SPEED:
                begin
                    if (u_done)
                    begin
                        speed_reg <= u_res[16:0];
                        state_reg <= rspm_pkg::ST_PACE;
                    end
                end
                rspm_pkg::ST_PACE:
                begin
                    if (u_done)
                    begin
                        pace_reg <= sat_res;
                        state_reg <= rspm_pkg::ST_DIST;
                    end
                end
                rspm_pkg::ST_DIST:
                begin
                    dprod_reg <= 49'(speed_reg) * 49'(dt_reg);
                    ex_reg <= (27'(peak_reg) * 27'd2943) >> FORCE_FRAC_BITS;
                    state_reg <= rspm_pkg::ST_OUT;
                end
                rspm_pkg::ST_OUT:
                begin
                    dist_reg <= (dsum[32] || dq[33:32] != 2'b00) ? '1 : dsum[31:0];
                    energy_reg <= esum[32] ? '1 : esum[31:0];
                    count_reg <= (count_reg == '1) ? count_reg : count_reg + 32'd1;
                    done_reg <= 1'b1;
                    out_valid_reg <= 1'b1;
                    state_reg <= rspm_pkg::ST_IDLE;
                end
                default: state_reg <= rspm_pkg::ST_IDLE;
            endcase
        end
    end

    // launch the unit on the first cycle of each compute state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_state_reg <= rspm_pkg::ST_IDLE;
        else
            prev_state_reg <= state_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, count_reg, energy_reg, dist_reg, pace_reg, power_reg,
                       rate_reg, peak_reg, done_reg, drive_reg};
endmodule

// File: test/rowing_stroke_power_meter_tb.sv
// Testbench for rowing_stroke_power_meter: a queue-fed driver and a monitor
// check every status transaction against a built-in stroke and power predictor.
// Depends on rspm_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps
module rowing_stroke_power_meter_tb;

    typedef struct {
        logic        pulling;
        logic        stroke_done;
        logic [14:0] peak_force;
        logic [15:0] spm;
        logic [15:0] watts;
        logic [15:0] pace;
        logic [31:0] distance;
        logic [31:0] energy;
        logic [31:0] strokes;
    } status_t;

    typedef struct {
        logic [15:0] force_val;
        logic [31:0] stamp;
    } sample_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_index = rspm_pkg::CFG_PULL;
    logic [14:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;

    rowing_stroke_power_meter dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #6 clk = ~clk;

    sample_t     sample_q[$];
    status_t     status_q[$];
    int          errors = 0;
    int          strokes_seen = 0;
    int          status_count = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    bit          no_idle = 0;
    logic [31:0] now_ms = 32'd1000;

    // predictor state
    logic [14:0] pull_lvl = 15'd64;
    logic [14:0] rel_lvl = 15'd32;
    logic        m_drive = 0;
    logic [14:0] m_peak = 0;
    logic [31:0] m_last = 0;
    logic        m_seen = 0;
    logic [15:0] m_rate = 0;
    logic [15:0] m_watts = 0;
    logic [15:0] m_pace = 0;
    logic [31:0] m_dist = 0;
    logic [31:0] m_energy = 0;
    logic [31:0] m_count = 0;

    function automatic longint unsigned cube_floor(longint unsigned num,
                                                   longint unsigned den,
                                                   longint unsigned hi);
        longint unsigned lo;
        longint unsigned mid;
        lo = 0;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (mid * mid * mid * den <= num)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, longint unsigned b);
        longint unsigned s;
        s = longint'(a) + b;
        return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] clip16(longint unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic status_t predict_status(sample_t smp);
        int              f;
        logic            done;
        logic [31:0]     d32;
        longint unsigned dt;
        longint unsigned p;
        longint unsigned w;
        longint unsigned spd;
        status_t         r;
        f = $signed(smp.force_val);
        done = 0;
        if (f > int'(pull_lvl))
        begin
            if (!m_drive)
            begin
                m_drive = 1;
                m_peak = 0;
            end
            if (f > int'(m_peak))
                m_peak = f[14:0];
        end
        else if (f < int'(rel_lvl) && m_drive)
        begin
            m_drive = 0;
            if (m_seen)
            begin
                d32 = smp.stamp - m_last;
                dt = d32;
                if (dt >= 2)
                begin
                    p = m_peak;
                    m_rate = clip16(60000 / dt);
                    m_watts = clip16((p * 5886) / (dt << rspm_pkg::FORCE_FRAC_BITS));
                    w = m_watts;
                    if (w == 0)
                    begin
                        spd = 0;
                        m_pace = 0;
                    end
                    else
                    begin
                        spd = cube_floor(10 * w * (64'd1 << 36), 28, 64'd1 << 17);
                        m_pace = clip16(cube_floor(64'd350000000000, w, 8192));
                    end
                    m_dist = add_sat(m_dist, (spd * dt) / 40960);
                    m_energy = add_sat(m_energy,
                        (p * 23544) / (64'd4184 << rspm_pkg::FORCE_FRAC_BITS));
                    m_count = add_sat(m_count, 1);
                    done = 1;
                end
            end
            m_last = smp.stamp;
            m_seen = 1;
        end
        r.pulling = m_drive;
        r.stroke_done = done;
        r.peak_force = m_peak;
        r.spm = m_rate;
        r.watts = m_watts;
        r.pace = m_pace;
        r.distance = m_dist;
        r.energy = m_energy;
        r.strokes = m_count;
        return r;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (no_idle || k < 65)
            return 0;
        if (k < 95)
            return $urandom_range(1, 4);
        return $urandom_range(15, 70);
    endfunction

    task automatic report(string name, longint unsigned got, longint unsigned want);
        $display("MISMATCH %0s: got %0d, expected %0d at %0t", name, got, want, $time);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
                tx_gap = pick_gap();
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                sample_t smp;
                smp = sample_q.pop_front();
                status_q.push_back(predict_status(smp));
                s_tdata <= {smp.stamp, smp.force_val};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                logic [167:0] v;
                status_t e;
                v = m_tdata;
                status_count++;
                if (status_q.size() == 0)
                    report("unexpected transaction", 1, 0);
                else
                begin
                    e = status_q.pop_front();
                    if (e.stroke_done)
                        strokes_seen++;
                    if (v[0] !== e.pulling) report("pulling", v[0], e.pulling);
                    if (v[1] !== e.stroke_done) report("stroke_done", v[1], e.stroke_done);
                    if (v[16:2] !== e.peak_force) report("peak_force", v[16:2], e.peak_force);
                    if (v[32:17] !== e.spm) report("strokes_per_minute", v[32:17], e.spm);
                    if (v[48:33] !== e.watts) report("power_watts", v[48:33], e.watts);
                    if (v[64:49] !== e.pace) report("pace_tenths", v[64:49], e.pace);
                    if (v[96:65] !== e.distance) report("distance_cm", v[96:65], e.distance);
                    if (v[128:97] !== e.energy) report("energy_millikcal", v[128:97], e.energy);
                    if (v[160:129] !== e.strokes) report("stroke_total", v[160:129], e.strokes);
                end
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                rx_gap = pick_gap();
                m_tready <= 1'b1;
            end
        end
    end

    task automatic add_sample(int f, int unsigned step);
        sample_t smp;
        now_ms = now_ms + step;
        smp.force_val = f[15:0];
        smp.stamp = now_ms;
        sample_q.push_back(smp);
    endtask

    function automatic int pull_force();
        int lo;
        lo = int'(pull_lvl) + 1;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(lo, 32767);
        return (lo + 400 > 32767) ? 32767 : $urandom_range(lo, lo + 400);
    endfunction

    function automatic int release_force();
        int hi;
        hi = int'(rel_lvl) - 1;
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, hi + 32768) - 32768;
        return (hi - 60 < -32768) ? -32768 : hi - $urandom_range(0, 60);
    endfunction

    task automatic add_stroke();
        int n;
        int unsigned period;
        int k;
        if (pull_lvl == 15'h7FFF)
        begin
            add_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 50));
            return;
        end
        n = $urandom_range(1, 5);
        repeat (n)
            add_sample(pull_force(), $urandom_range(0, 60));
        if ($urandom_range(0, 3) == 0 && int'(rel_lvl) <= int'(pull_lvl))
            add_sample($urandom_range(rel_lvl, pull_lvl), $urandom_range(0, 30));
        k = $urandom_range(0, 19);
        if (k == 0)
            period = $urandom_range(0, 1);
        else if (k == 1)
            period = $urandom();
        else if (k < 5)
            period = $urandom_range(2, 100);
        else
            period = $urandom_range(300, 4000);
        add_sample(release_force(), period);
    endtask

    task automatic write_reg(logic idx, logic [14:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == rspm_pkg::CFG_PULL)
            pull_lvl = val;
        else
            rel_lvl = val;
    endtask

    task automatic wait_idle();
        wait (sample_q.size() == 0 && status_q.size() == 0 && !s_tvalid);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        logic [14:0] pulls[8];
        logic [14:0] rels[8];
        int          cnt;
        pulls = '{15'd64, 15'd0, 15'h7FFF, 15'd100, 15'h7FFF, 15'd1000, 15'd0, 15'd0};
        rels  = '{15'd32, 15'd0, 15'h7FFF, 15'd200, 15'd0,    15'd500,  15'd0, 15'd0};
        pulls[6] = $urandom_range(0, 32767);
        rels[6] = $urandom_range(0, 32767);
        pulls[7] = $urandom_range(0, 2000);
        rels[7] = $urandom_range(0, pulls[7]);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: idle release, extremes, first release, short period, wrap
        add_sample(-32768, 5);
        add_sample(0, 1);
        add_sample(64, 1);
        add_sample(65, 1);
        add_sample(32767, 10);
        add_sample(40, 3);
        add_sample(31, 200);
        add_sample(32767, 100);
        add_sample(-32768, 400);
        add_sample(500, 10);
        add_sample(20, 1);
        add_sample(300, 10);
        add_sample(0, 0);
        now_ms = 32'hFFFF_FF00;
        add_sample(32767, 0);
        add_sample(-1, 2);
        add_sample(200, 300);
        add_sample(10, 600);
        add_sample(1000, 100);
        add_sample(-5, 2);
        add_sample(16'h5555, 50);
        add_sample(-16'sh5556, 900);
        add_sample(32767, 10);
        add_sample(0, 32'hAAAA_AAAA);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                wait_idle();
                write_reg(rspm_pkg::CFG_PULL, pulls[ph]);
                write_reg(rspm_pkg::CFG_RELEASE, rels[ph]);
                @(posedge clk);
                cfg_we <= 1'b0;
                @(posedge clk);
            end
            no_idle = (ph == 3);
            cnt = 0;
            while (cnt < 80)
            begin
                int before_n;
                before_n = sample_q.size();
                if ($urandom_range(0, 9) < 8)
                    add_stroke();
                else
                    add_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 200));
                cnt += sample_q.size() - before_n;
                wait (sample_q.size() < 4);
            end
        end

        wait (sample_q.size() == 0 && status_q.size() == 0);
        repeat (600) @(posedge clk);
        $display("Covered %0d status transactions, %0d counted strokes, 8 threshold settings.",
                 status_count, strokes_seen);
        if (errors == 0 && status_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #12ms;
        $display("Timeout with %0d transactions outstanding", status_q.size());
        $display("Test completed with failures");
        $finish;
    end
endmodule

// File: rowing_stroke_power_meter.f
hw/rtl/rspm_pkg.sv
hw/rtl/rspm_unit.sv
hw/rtl/rowing_stroke_power_meter.sv
test/rowing_stroke_power_meter_tb.sv
